// ===== rtl/lle_pkg.sv =====
// ----------------------------------------------------------------------------
// lle_pkg
// Shared types and codes for the lowest-address leader election block.
// ----------------------------------------------------------------------------
package lle_pkg;

  localparam int unsigned AddrW = 48;
  localparam int unsigned TimeW = 32;

  typedef enum logic [2:0] {
    OP_HEARTBEAT = 3'd0,
    OP_ELECTION  = 3'd1,
    OP_DATA      = 3'd2,
    OP_TICK      = 3'd3,
    OP_BOOT      = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ROLE_NONE     = 2'd0,
    ROLE_FOLLOWER = 2'd1,
    ROLE_LEADER   = 2'd2
  } role_e;

  typedef enum logic [2:0] {
    REG_OWN_ADDR = 3'd0,
    REG_MASTER_TO = 3'd1,
    REG_WINDOW   = 3'd2,
    REG_STALE_TO = 3'd3,
    REG_HANDLER  = 3'd4
  } reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_PURGE,
    ST_OUT
  } state_e;

  // one peer table entry
  typedef struct packed {
    logic [AddrW-1:0] addr;
    logic [TimeW-1:0] seen;
  } peer_t;

endpackage

// ===== rtl/lle_peer_mem.sv =====
// ----------------------------------------------------------------------------
// lle_peer_mem
// Peer table memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lle_peer_mem
  import lle_pkg::*;
#(
  parameter int unsigned Depth = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  peer_t                    wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output peer_t                    rdata_o
);

  peer_t mem [Depth];
  peer_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/lowest_id_leader_election_top.sv =====
// ----------------------------------------------------------------------------
// lowest_id_leader_election_top
// Node-side lowest-address leader election with a peer table in memory.
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one event item: op, peer address, master flag, time stamp.
//   m_axis returns exactly one status item per event item.
//   cfg_we_i/cfg_idx_i/cfg_data_i write the five settings while idle.
// sequencing:
//   one item at a time; the peer table is swept through its single read
//   port, one entry a cycle. data, boot and ignored items are offered in
//   the cycle after the accepting edge. heartbeat and election items pass
//   through a scan for lowest, then a decide step; a tick goes on after the
//   decide step to an in-order purge pass that compacts in place.
// reset:
//   control state clears at once; table contents are undefined and are
//   only read below the fill count, so no clearing pass is needed.
// stall:
//   the result is held in the output register until taken; the next input
//   item is accepted only after that.
// ----------------------------------------------------------------------------
module lowest_id_leader_election_top
  import lle_pkg::*;
#(
  parameter int unsigned MAX_PEERS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [47:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // op[2:0], peer_address[50:3], master_flag_in[51], now_ms[83:52], zeros
  input  logic [87:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // role[1:0], master_known[2], master_address[50:3], peers_held[54:51],
  // send_election[55], send_heartbeat[56], heartbeat_master[57],
  // became_master[58], forward_data[59], zeros
  output logic [63:0] m_axis_tdata
);

  localparam int unsigned IdxW = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
  localparam int unsigned CntW = $clog2(MAX_PEERS + 1);

  // configuration
  logic [AddrW-1:0] own_q;
  logic [TimeW-1:0] mto_q, sto_q;
  logic [15:0]      win_q;
  logic             hnd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_q <= '0;
      mto_q <= 32'd15000;
      win_q <= 16'd500;
      sto_q <= 32'd30000;
      hnd_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_OWN_ADDR:  own_q <= cfg_data_i;
        REG_MASTER_TO: mto_q <= cfg_data_i[31:0];
        REG_WINDOW:    win_q <= cfg_data_i[15:0];
        REG_STALE_TO:  sto_q <= cfg_data_i[31:0];
        REG_HANDLER:   hnd_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // item fields
  logic [2:0]       op_q, op_d;
  logic [AddrW-1:0] addr_q, addr_d;
  logic             mflag_q, mflag_d;
  logic [TimeW-1:0] now_q, now_d;

  // election state
  role_e            role_q, role_d;
  logic             mval_q, mval_d;
  logic [AddrW-1:0] maddr_q, maddr_d;
  logic [TimeW-1:0] mseen_q, mseen_d;
  logic [TimeW-1:0] estart_q, estart_d;
  logic             eact_q, eact_d;
  logic [CntW-1:0]  total_q, total_d;

  // sweep control
  state_e           st_q, st_d;
  logic [CntW-1:0]  ridx_q, ridx_d;   // read address issued
  logic [CntW-1:0]  widx_q, widx_d;   // purge write position
  logic             rv_q, rv_d;       // read data valid this cycle
  logic [CntW-1:0]  rpos_q, rpos_d;   // index of returned data
  logic             found_q, found_d;
  logic [IdxW-1:0]  fidx_q, fidx_d;
  logic [AddrW-1:0] low_q, low_d;
  logic             sel_q, sel_d, shb_q, shb_d, hbm_q, hbm_d;
  logic             won_q, won_d, fwd_q, fwd_d;

  // memory port
  logic            we;
  logic [IdxW-1:0] waddr, raddr;
  peer_t           wdata, rdata;

  lle_peer_mem #(.Depth(1 << IdxW)) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign raddr = ridx_q[IdxW-1:0];

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          case (s_axis_tdata[2:0])
            OP_HEARTBEAT, OP_ELECTION, OP_TICK: st_d = ST_SCAN;
            default:                            st_d = ST_OUT;
          endcase
        end
      end
      ST_SCAN:   if (ridx_q == total_q && !rv_q) st_d = ST_DECIDE;
      ST_DECIDE: st_d = (op_q == OP_TICK) ? ST_PURGE : ST_OUT;
      ST_PURGE:  if (ridx_q == total_q && !rv_q) st_d = ST_OUT;
      ST_OUT:    if (m_axis_tready) st_d = ST_IDLE;
      default:   st_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    logic       hit;
    logic       ins;
    logic       win;
    op_d = op_q; addr_d = addr_q; mflag_d = mflag_q; now_d = now_q;
    role_d = role_q; mval_d = mval_q; maddr_d = maddr_q; mseen_d = mseen_q;
    estart_d = estart_q; eact_d = eact_q; total_d = total_q;
    ridx_d = ridx_q; widx_d = widx_q; rv_d = 1'b0; rpos_d = ridx_q;
    found_d = found_q; fidx_d = fidx_q; low_d = low_q;
    sel_d = sel_q; shb_d = shb_q; hbm_d = hbm_q; won_d = won_q; fwd_d = fwd_q;
    we = 1'b0; waddr = '0; wdata = '{addr: addr_q, seen: now_q};
    hit = 1'b0; ins = 1'b0; win = 1'b0;
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;

    case (st_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          op_d = s_axis_tdata[2:0];
          addr_d = s_axis_tdata[50:3];
          mflag_d = s_axis_tdata[51];
          now_d = s_axis_tdata[83:52];
          ridx_d = '0; widx_d = '0;
          found_d = 1'b0; fidx_d = '0;
          low_d = own_q;
          sel_d = 1'b0; shb_d = 1'b0; hbm_d = 1'b0; won_d = 1'b0; fwd_d = 1'b0;
          case (s_axis_tdata[2:0])
            OP_DATA: fwd_d = (role_q == ROLE_LEADER) && hnd_q;
            OP_BOOT: begin
              if (!eact_q) begin
                eact_d = 1'b1; estart_d = s_axis_tdata[83:52];
                role_d = ROLE_FOLLOWER; sel_d = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end

      ST_SCAN: begin
        if (ridx_q != total_q) begin
          ridx_d = ridx_q + 1'b1;
          rv_d = 1'b1;
        end
        if (rv_q) begin
          if (rdata.addr == addr_q && !found_q) begin
            found_d = 1'b1;
            fidx_d = rpos_q[IdxW-1:0];
          end
          if (rdata.addr < low_q) low_d = rdata.addr;
        end
      end

      ST_DECIDE: begin
        ridx_d = '0; widx_d = '0;
        case (op_q)
          OP_HEARTBEAT: begin
            hit = found_q || (total_q < CntW'(MAX_PEERS));
            ins = !found_q && hit;
            if (hit) begin
              we = 1'b1;
              waddr = found_q ? fidx_q : total_q[IdxW-1:0];
              if (ins) total_d = total_q + 1'b1;
              if (mflag_q) begin
                maddr_d = addr_q; mval_d = 1'b1; mseen_d = now_q;
              end
            end
          end
          OP_ELECTION: begin
            if (!found_q && total_q < CntW'(MAX_PEERS)) begin
              we = 1'b1;
              waddr = total_q[IdxW-1:0];
              total_d = total_q + 1'b1;
            end
            if (addr_q < own_q) eact_d = 1'b0;
          end
          default: begin
            // tick: settle, master loss, heartbeat
            win = eact_q && ((now_q - estart_q) > {16'd0, win_q});
            if (win) begin
              eact_d = 1'b0;
              maddr_d = low_q; mval_d = 1'b1;
              if (low_q == own_q) begin
                role_d = ROLE_LEADER; won_d = hnd_q;
              end else begin
                role_d = ROLE_FOLLOWER;
              end
            end
            if ((win ? (low_q != own_q) : (role_q == ROLE_FOLLOWER)) &&
                (win || mval_q) && ((now_q - mseen_q) > mto_q)) begin
              mval_d = 1'b0;
              if (!(eact_q && !win)) begin
                eact_d = 1'b1; estart_d = now_q; role_d = ROLE_FOLLOWER;
                sel_d = 1'b1;
              end
            end
            shb_d = 1'b1;
            hbm_d = win ? (low_q == own_q) : (role_q == ROLE_LEADER);
          end
        endcase
      end

      ST_PURGE: begin
        if (ridx_q != total_q) begin
          ridx_d = ridx_q + 1'b1;
          rv_d = 1'b1;
        end
        if (rv_q) begin
          if ((now_q - rdata.seen) <= sto_q) begin
            we = 1'b1;
            waddr = widx_q[IdxW-1:0];
            wdata = rdata;
            widx_d = widx_q + 1'b1;
          end
        end
        if (ridx_q == total_q && !rv_q) total_d = widx_q;
      end

      ST_OUT: m_axis_tvalid = 1'b1;

      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      role_q <= ROLE_NONE; mval_q <= 1'b0; maddr_q <= '0; mseen_q <= '0;
      estart_q <= '0; eact_q <= 1'b0; total_q <= '0;
      ridx_q <= '0; widx_q <= '0; rv_q <= 1'b0; rpos_q <= '0;
      found_q <= 1'b0;
    end else begin
      st_q <= st_d;
      role_q <= role_d; mval_q <= mval_d; maddr_q <= maddr_d; mseen_q <= mseen_d;
      estart_q <= estart_d; eact_q <= eact_d; total_q <= total_d;
      ridx_q <= ridx_d; widx_q <= widx_d; rv_q <= rv_d; rpos_q <= rpos_d;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; addr_q <= addr_d; mflag_q <= mflag_d; now_q <= now_d;
    fidx_q <= fidx_d; low_q <= low_d;
    sel_q <= sel_d; shb_q <= shb_d; hbm_q <= hbm_d; won_q <= won_d; fwd_q <= fwd_d;
  end

  assign m_axis_tdata = {4'd0, fwd_q, won_q, hbm_q, shb_q, sel_q,
                         4'(total_q), (mval_q ? maddr_q : 48'd0), mval_q, role_q};

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the lowest-address leader election block: event
// items from directed and random tests, results checked against an internal
// election predictor under several idling phases and register settings.
// ----------------------------------------------------------------------------
module testbench
  import lle_pkg::*;
();

  typedef struct packed {
    logic        forward_data;
    logic        became_master;
    logic        heartbeat_master;
    logic        send_heartbeat;
    logic        send_election;
    logic [3:0]  peers_held;
    logic [47:0] master_address;
    logic        master_known;
    logic [1:0]  role;
  } status_t;

  localparam int NPEER = 8;
  localparam int WDOG_LIMIT = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [47:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [87:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;

  lowest_id_leader_election_top dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // election state mirror
  logic [47:0] cf_own;
  logic [31:0] cf_mto, cf_stale;
  logic [15:0] cf_win;
  logic        cf_hnd;
  role_e       p_role;
  logic        p_mvalid, p_elec;
  logic [47:0] p_maddr;
  logic [31:0] p_mseen, p_estart;
  logic [47:0] p_addr [NPEER];
  logic [31:0] p_seen [NPEER];
  int          p_total;

  status_t status_q[$];
  int sent_n, got_n, errors;
  int send_idle_pct, recv_stall_pct;
  bit hold_off;
  int wdog;
  logic [31:0] clock_ms;

  function automatic int peer_find(logic [47:0] a);
    for (int i = 0; i < p_total; i++) if (p_addr[i] == a) return i;
    return -1;
  endfunction

  function automatic void peer_add(logic [47:0] a, logic [31:0] t);
    if (p_total < NPEER) begin
      p_addr[p_total] = a;
      p_seen[p_total] = t;
      p_total++;
    end
  endfunction

  function automatic bit open_vote(logic [31:0] t);
    if (p_elec) return 1'b0;
    p_elec = 1'b1;
    p_estart = t;
    p_role = ROLE_FOLLOWER;
    return 1'b1;
  endfunction

  function automatic status_t predict_status(logic [2:0] op, logic [47:0] a,
                                             logic mf, logic [31:0] t);
    status_t r;
    int k, i;
    logic [47:0] low;
    r = '0;
    case (op)
      OP_HEARTBEAT: begin
        k = peer_find(a);
        if (k < 0 && p_total < NPEER) begin
          peer_add(a, t);
          k = p_total - 1;
        end
        if (k >= 0) begin
          p_seen[k] = t;
          if (mf) begin
            p_maddr = a;
            p_mvalid = 1'b1;
            p_mseen = t;
          end
        end
      end
      OP_ELECTION: begin
        if (peer_find(a) < 0) peer_add(a, t);
        if (a < cf_own) p_elec = 1'b0;
      end
      OP_DATA: r.forward_data = (p_role == ROLE_LEADER) && cf_hnd;
      OP_TICK: begin
        if (p_elec && (t - p_estart) > {16'd0, cf_win}) begin
          p_elec = 1'b0;
          low = cf_own;
          for (i = 0; i < p_total; i++) if (p_addr[i] < low) low = p_addr[i];
          p_maddr = low;
          p_mvalid = 1'b1;
          if (low == cf_own) begin
            p_role = ROLE_LEADER;
            r.became_master = cf_hnd;
          end else p_role = ROLE_FOLLOWER;
        end
        if (p_role == ROLE_FOLLOWER && p_mvalid && (t - p_mseen) > cf_mto) begin
          p_mvalid = 1'b0;
          r.send_election = open_vote(t);
        end
        r.send_heartbeat = 1'b1;
        r.heartbeat_master = (p_role == ROLE_LEADER);
        i = 0;
        while (i < p_total) begin
          if ((t - p_seen[i]) > cf_stale) begin
            for (int j = i; j + 1 < p_total; j++) begin
              p_addr[j] = p_addr[j+1];
              p_seen[j] = p_seen[j+1];
            end
            p_total--;
          end else i++;
        end
      end
      OP_BOOT: r.send_election = open_vote(t);
      default: ;
    endcase
    r.role = p_role;
    r.master_known = p_mvalid;
    r.master_address = p_mvalid ? p_maddr : '0;
    r.peers_held = p_total[3:0];
    return r;
  endfunction

  // valid stays up after an accept until the next item or an idle cycle
  task automatic send_event(logic [2:0] op, logic [47:0] a, logic mf, logic [31:0] t);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    status_q.push_back(predict_status(op, a, mf, t));
    s_axis_tdata <= {4'd0, t, mf, a, op};
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent_n++;
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_e idx, logic [47:0] v);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    case (idx)
      REG_OWN_ADDR:  cf_own = v;
      REG_MASTER_TO: cf_mto = v[31:0];
      REG_WINDOW:    cf_win = v[15:0];
      REG_STALE_TO:  cf_stale = v[31:0];
      default:       cf_hnd = v[0];
    endcase
  endtask

  task automatic set_all(logic [47:0] own, logic [31:0] mto, logic [15:0] win,
                         logic [31:0] stale, logic hnd);
    write_reg(REG_OWN_ADDR, own);
    write_reg(REG_MASTER_TO, {16'd0, mto});
    write_reg(REG_WINDOW, {32'd0, win});
    write_reg(REG_STALE_TO, {16'd0, stale});
    write_reg(REG_HANDLER, {47'd0, hnd});
    cfg_we_i <= 1'b0;
  endtask

  // result check
  always @(posedge clk_i) begin
    status_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[59:0];
      got_n++;
      if (status_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
      end else begin
        want = status_q.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display({"mismatch: role %0d/%0d known %0d/%0d maddr %h/%h peers %0d/%0d",
                      " el %0d/%0d hb %0d/%0d hbm %0d/%0d won %0d/%0d fwd %0d/%0d",
                      " (exp/act)"},
                     want.role, got.role, want.master_known, got.master_known,
                     want.master_address, got.master_address, want.peers_held,
                     got.peers_held, want.send_election, got.send_election,
                     want.send_heartbeat, got.send_heartbeat,
                     want.heartbeat_master, got.heartbeat_master,
                     want.became_master, got.became_master,
                     want.forward_data, got.forward_data);
        end
      end
    end
  end

  // receiver readiness, with a long hold-off on request
  initial begin
    int n;
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        m_axis_tready <= 1'b0;
        for (n = 0; n < 300; n++) @(posedge clk_i);
        hold_off = 1'b0;
      end
      m_axis_tready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end
  end

  // stall watchdog
  initial begin
    wdog = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        wdog = 0;
      else wdog++;
      if (wdog >= WDOG_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", WDOG_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  function automatic logic [47:0] rand_addr();
    return 48'({$urandom, $urandom});
  endfunction

  task automatic test_directed;
    logic [47:0] ones;
    ones = '1;
    set_all(48'h0000_0000_0100, 32'd1000, 16'd500, 32'd30000, 1'b1);
    send_event(3'd5, ones, 1'b1, 32'd0);
    send_event(3'd7, 48'd0, 1'b0, 32'd1);
    send_event(OP_DATA, 48'd0, 1'b0, 32'd2);
    send_event(OP_BOOT, 48'd0, 1'b0, 32'd10);
    send_event(OP_BOOT, 48'd0, 1'b0, 32'd20);        // election already running
    send_event(OP_ELECTION, ones, 1'b0, 32'd30);
    send_event(OP_TICK, 48'd0, 1'b0, 32'd510);       // window edge, no settle
    send_event(OP_TICK, 48'd0, 1'b0, 32'd511);       // settle as master
    send_event(OP_DATA, 48'd0, 1'b0, 32'd512);
    send_event(OP_ELECTION, 48'h100, 1'b0, 32'd520); // own address heard
    for (int i = 0; i < 8; i++) send_event(OP_HEARTBEAT, 48'h200 + i, i[0], 32'd600 + i);
    send_event(OP_HEARTBEAT, 48'd5, 1'b1, 32'd700);  // table full, dropped
    send_event(OP_ELECTION, 48'd1, 1'b0, 32'd710);   // full, still compared
    send_event(OP_HEARTBEAT, 48'h203, 1'b1, 32'd800);
    send_event(OP_TICK, 48'd0, 1'b0, 32'd40000);     // purge stale
    send_event(OP_TICK, 48'd0, 1'b0, 32'hFFFF_FFFF);
    drain();
  endtask

  // mostly well-formed rounds of heartbeats, elections, ticks, data and boot items
  task automatic run_random(int n_items);
    logic [2:0] op;
    logic [47:0] a;
    logic [47:0] pool [6];
    for (int i = 0; i < 6; i++) pool[i] = rand_addr();
    pool[0] = cf_own - 1;
    pool[1] = cf_own + 1;
    for (int i = 0; i < n_items; i++) begin
      clock_ms += $urandom_range(4) == 0 ? $urandom : $urandom_range(400);
      case ($urandom_range(19))
        0, 1, 2, 3, 4, 5: op = OP_HEARTBEAT;
        6, 7, 8: op = OP_ELECTION;
        9, 10: op = OP_DATA;
        11, 12, 13, 14, 15: op = OP_TICK;
        16, 17: op = OP_BOOT;
        default: op = 3'($urandom_range(7));
      endcase
      a = $urandom_range(3) == 0 ? rand_addr() : pool[$urandom_range(5)];
      send_event(op, a, 1'($urandom_range(1)), clock_ms);
    end
  endtask

  task automatic test_no_idle;
    send_idle_pct = 0; recv_stall_pct = 0;
    set_all(rand_addr(), 32'd800, 16'd300, 32'd2000, 1'b1);
    run_random(300);
    drain();
  endtask

  task automatic test_sender_idle;
    send_idle_pct = 78; recv_stall_pct = 0;
    set_all(48'd0, 32'd0, 16'd0, 32'd0, 1'b0);
    run_random(250);
    drain();
  endtask

  task automatic test_receiver_stall;
    send_idle_pct = 0; recv_stall_pct = 78;
    set_all(48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
    run_random(250);
    drain();
  endtask

  task automatic test_both_idle;
    send_idle_pct = 32; recv_stall_pct = 32;
    set_all(rand_addr(), 32'd1500, 16'd100, 32'd5000, 1'b1);
    run_random(300);
    drain();
  endtask

  task automatic test_backpressure;
    send_idle_pct = 0; recv_stall_pct = 0;
    hold_off = 1'b1;
    run_random(200);
    drain();
  endtask

  initial begin
    errors = 0; sent_n = 0; got_n = 0; hold_off = 1'b0;
    send_idle_pct = 0; recv_stall_pct = 0; clock_ms = 32'd1000;
    cf_own = '0; cf_mto = 32'd15000; cf_win = 16'd500;
    cf_stale = 32'd30000; cf_hnd = 1'b0;
    p_role = ROLE_NONE; p_mvalid = 1'b0; p_maddr = '0; p_mseen = '0;
    p_estart = '0; p_elec = 1'b0; p_total = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_no_idle();
    test_sender_idle();
    test_receiver_stall();
    test_both_idle();
    test_backpressure();
    $display("sent %0d event items, checked %0d status items over six phases",
             sent_n, got_n);
    $display("register extremes, table overflow, purge and election settle exercised");
    if (errors == 0 && status_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, status_q.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/lle_pkg.sv
rtl/lle_peer_mem.sv
rtl/lowest_id_leader_election_top.sv
tb/sv/testbench.sv
